@@ hdl/dtdc_pkg.sv @@
// dtdc_pkg: shared widths, register indexes, fixed-point constants and the
// integer square root used to build the exp2 table at elaboration
// no dependencies
package dtdc_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	typedef enum logic [CFG_IW-1:0] {
		REG_MODE    = 3'd0,
		REG_BASE    = 3'd1,
		REG_RATIO   = 3'd2,
		REG_INV_VOL = 3'd3,
		REG_ROW     = 3'd4
	} cfg_reg_t;

	localparam logic MODE_CONST   = 1'b0;
	localparam logic MODE_DENSITY = 1'b1;

	// signed q.16 log / exponent width, exp2 result, divider operand, quotient
	localparam int LW  = 23;
	localparam int IPW = LW - 16;
	localparam int YW  = 34;
	localparam int DW  = 34;
	localparam int QW  = 16;

	localparam logic [15:0] K_POW_A   = 16'd60293;
	localparam logic [15:0] K_POW_B   = 16'd64881;
	localparam logic [14:0] K_NUM     = 15'd28180;
	localparam logic [14:0] K_DEN     = 15'd17695;
	localparam logic [19:0] K_DEN_OFS = 20'd733348;
	localparam logic [16:0] ONE_Q16   = 17'h10000;

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n = n_in;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > n) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

endpackage

@@ hdl/density_to_diffusion_coefficient.sv @@
// density_to_diffusion_coefficient: per-cell diffusion coefficient from biomass
// top level; uses dtdc_pkg, dtdc_exp2 and dtdc_div
//
// One cell request is taken every clock; the pipeline stalls as a whole only
// while the output register holds a result that is not taken. The pipeline
// holds the log2 stages, the exp2 unit and the 17-stage quotient pipeline of
// the density factor. Every request gives one result; ghost cells and indexes
// beyond MAX_CELLS come out with the write flag low and a zero coefficient.
module density_to_diffusion_coefficient #(
	parameter int MAX_CELLS     = 1048576,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dtdc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [dtdc_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [55:0]                 s_tdata,  // cell_index[19:0], biomass[51:20]
	input  logic [0:0]                  s_tuser,  // ghost
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_tdata,  // cell_index_out, target_row, coefficient
	output logic [0:0]                  m_tuser   // write_enable
);
	import dtdc_pkg::*;

	localparam int AW  = $clog2(TABLE_ENTRIES + 1);
	localparam int NST = 33;

	typedef logic [16:0] log_tab_t [TABLE_ENTRIES+1];

	typedef struct packed {
		logic [19:0] cidx;
		logic        active;
		logic        bio_nz;
		logic        xz;
		logic [31:0] m0c;
	} side_t;

	function automatic log_tab_t build_log();
		logic [63:0] v;
		logic [63:0] acc;
		log_tab_t t;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			v = (64'(TABLE_ENTRIES + k) << 30) / TABLE_ENTRIES;
			acc = '0;
			for (int j = 0; j < 20; j++) begin
				v = (v * v) >> 30;
				acc = acc << 1;
				if (v >= (64'd2 << 30)) begin
					acc = acc | 64'd1;
					v = v >> 1;
				end
			end
			t[k] = 17'((acc + 64'd8) >> 4);
		end
		t[TABLE_ENTRIES] = 17'd65536;
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log();

	logic        mode_q;
	logic [31:0] base_q;
	logic [17:0] ratio_q;
	logic [31:0] inv_vol_q;
	logic [3:0]  row_q;

	logic        adv;
	logic        vld_q [1:NST];
	side_t       side_q [1:NST];

	logic [19:0] cell_in;
	logic [31:0] bio_in;

	logic [63:0]      pr_s1;
	logic [49:0]      m0p_s1;
	logic [31:0]      x_c;
	logic [4:0]       e_c;
	logic [31:0]      xsh_c;
	logic [49:0]      m0r_c;
	logic [31:0]      m0c_c;
	logic [4:0]       e_s2, e_s3, e_s4, e_s5;
	logic [30:0]      frac_s2;
	logic [31+AW-1:0] pos_c;
	logic [AW-1:0]    idx_s3;
	logic [30:0]      r_s3, r_s4;
	logic [16:0]      lo_s4, hi_s4, lo_s5;
	logic [47:0]      dr_s5;
	logic [47:0]      rnd_c;
	logic [LW-1:0]    tsum_c;
	logic [LW-1:0]    l_s6;
	logic [LW-1:0]    mag_c;
	logic             neg_s7;
	logic [38:0]      pa_s7, pb_s7;
	logic [38:0]      ra_c, rb_c;
	logic [LW-1:0]    a_s8, b_s8;
	logic [YW-1:0]    y_s13, z_s13;
	logic [48:0]      np_s14, dp_s14;
	logic [48:0]      nr_c, dr_c;
	logic [DW-1:0]    num_s15, den_s15;
	logic             ovf_s32;
	logic [QW-1:0]    q_s32;
	logic [16:0]      fac_c;
	logic [48:0]      cprod_s33;
	logic [48:0]      c1_c;
	logic [31:0]      coef1_c;

	logic        out_v_q;
	logic [19:0] out_cell_q;
	logic        out_we_q;
	logic [31:0] out_coef_q;

	assign adv = ~out_v_q | m_tready;
	assign s_tready = adv;
	assign cell_in = s_tdata[19:0];
	assign bio_in = s_tdata[51:20];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CONST;
			base_q <= '0;
			ratio_q <= 18'd65536;
			inv_vol_q <= 32'd65536;
			row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:    mode_q <= cfg_data[0];
				REG_BASE:    base_q <= cfg_data;
				REG_RATIO:   ratio_q <= cfg_data[17:0];
				REG_INV_VOL: inv_vol_q <= cfg_data;
				REG_ROW:     row_q <= cfg_data[3:0];
				default:     ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) vld_q[k] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NST; k++) vld_q[k] <= vld_q[k-1];
			out_v_q <= vld_q[NST];
		end
	end

	// stage 2 comb: saturate density, normalize, mode 0 rounding
	always_comb begin
		x_c = |pr_s1[63:48] ? 32'hFFFF_FFFF : pr_s1[47:16];
		e_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (x_c[i]) e_c = 5'(i);
		end
		xsh_c = x_c << (5'd31 - e_c);
		m0r_c = m0p_s1 + 50'h8000;
		m0c_c = |m0r_c[49:48] ? 32'hFFFF_FFFF : m0r_c[47:16];
	end

	assign pos_c = (31+AW)'(frac_s2) * (31+AW)'(TABLE_ENTRIES);
	assign rnd_c = (dr_s5 + 48'h4000_0000) >> 31;
	assign tsum_c = LW'({e_s5, 16'b0}) + LW'(lo_s5) + LW'(rnd_c);
	assign mag_c = l_s6[LW-1] ? ~l_s6 + LW'(1) : l_s6;
	assign ra_c = (pa_s7 + 39'h8000) >> 16;
	assign rb_c = (pb_s7 + 39'h8000) >> 16;
	assign nr_c = (np_s14 + 49'h8000) >> 16;
	assign dr_c = (dp_s14 + 49'h8000) >> 16;

	always_comb begin
		if (side_q[32].xz) fac_c = ONE_Q16;
		else if (ovf_s32) fac_c = '0;
		else fac_c = ONE_Q16 - 17'(q_s32);
		c1_c = cprod_s33 + 49'h8000;
		coef1_c = c1_c[48] ? 32'hFFFF_FFFF : c1_c[47:16];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[1] <= '{cidx: cell_in,
				active: ~s_tuser[0] && ({5'b0, cell_in} < 25'(MAX_CELLS)),
				bio_nz: |bio_in, xz: 1'b0, m0c: '0};
			side_q[2] <= '{cidx: side_q[1].cidx, active: side_q[1].active,
				bio_nz: side_q[1].bio_nz, xz: ~|x_c, m0c: m0c_c};
			for (int k = 3; k <= NST; k++) side_q[k] <= side_q[k-1];

			pr_s1 <= 64'(bio_in) * 64'(inv_vol_q);
			m0p_s1 <= 50'(base_q) * 50'(ratio_q);

			e_s2 <= e_c;
			frac_s2 <= xsh_c[30:0];

			e_s3 <= e_s2;
			idx_s3 <= pos_c[31 +: AW];
			r_s3 <= pos_c[30:0];

			e_s4 <= e_s3;
			r_s4 <= r_s3;
			lo_s4 <= LOG_TAB[idx_s3];
			hi_s4 <= LOG_TAB[idx_s3 + AW'(1)];

			e_s5 <= e_s4;
			lo_s5 <= lo_s4;
			dr_s5 <= 48'(hi_s4 - lo_s4) * 48'(r_s4);

			l_s6 <= tsum_c - LW'(1048576);

			neg_s7 <= l_s6[LW-1];
			pa_s7 <= 39'(mag_c) * 39'(K_POW_A);
			pb_s7 <= 39'(mag_c) * 39'(K_POW_B);

			a_s8 <= neg_s7 ? ~ra_c[LW-1:0] + LW'(1) : ra_c[LW-1:0];
			b_s8 <= neg_s7 ? ~rb_c[LW-1:0] + LW'(1) : rb_c[LW-1:0];

			np_s14 <= 49'(y_s13) * 49'(K_NUM);
			dp_s14 <= 49'(z_s13) * 49'(K_DEN);

			num_s15 <= DW'(nr_c);
			den_s15 <= DW'(K_DEN_OFS) + DW'(dr_c);

			cprod_s33 <= 49'(base_q) * 49'(fac_c);

			out_cell_q <= side_q[NST].cidx;
			if (!side_q[NST].active) begin
				out_we_q <= 1'b0;
				out_coef_q <= '0;
			end else if (mode_q == MODE_CONST) begin
				out_we_q <= side_q[NST].bio_nz;
				out_coef_q <= side_q[NST].bio_nz ? side_q[NST].m0c : '0;
			end else begin
				out_we_q <= 1'b1;
				out_coef_q <= coef1_c;
			end
		end
	end

	dtdc_exp2 #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_exp_a (
		.clk (clk),
		.en  (adv),
		.a   (a_s8),
		.y   (y_s13)
	);

	dtdc_exp2 #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_exp_b (
		.clk (clk),
		.en  (adv),
		.a   (b_s8),
		.y   (z_s13)
	);

	dtdc_div u_div (
		.clk (clk),
		.en  (adv),
		.num (num_s15),
		.den (den_s15),
		.ovf (ovf_s32),
		.q   (q_s32)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_coef_q, row_q, out_cell_q};
	assign m_tuser = out_we_q;

endmodule

@@ hdl/dtdc_exp2.sv @@
// dtdc_exp2: five-stage 2^a for a signed q.16 exponent, q18.16 result
// interpolated exp2 table built at elaboration; uses dtdc_pkg
module dtdc_exp2 #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [dtdc_pkg::LW-1:0]      a,
	output logic [dtdc_pkg::YW-1:0]      y
);
	import dtdc_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES + 1);

	typedef logic [17:0] exp_tab_t [TABLE_ENTRIES+1];

	function automatic exp_tab_t build_exp();
		logic [63:0] roots [21];
		logic [63:0] f;
		logic [63:0] p;
		exp_tab_t t;
		roots[0] = 64'd2 << 30;
		for (int j = 1; j <= 20; j++) roots[j] = isqrt64(roots[j-1] << 30);
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			f = (64'(k) << 20) / TABLE_ENTRIES;
			p = 64'd1 << 30;
			for (int j = 1; j <= 20; j++) begin
				if (f[20-j]) p = (p * roots[j] + (64'd1 << 29)) >> 30;
			end
			t[k] = 18'((p + (64'd1 << 13)) >> 14);
		end
		t[TABLE_ENTRIES] = 18'd131072;
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp();

	logic [16+AW-1:0] pos;
	logic [IPW-1:0]   ip_s1, ip_s2, ip_s3, ip_s4;
	logic [AW-1:0]    idx_s1;
	logic [15:0]      r_s1, r_s2;
	logic [17:0]      lo_s2, hi_s2, lo_s3, mant_s4;
	logic [33:0]      m_s3;
	logic [IPW-1:0]   sneg;
	logic [34:0]      ext;
	logic [34:0]      yneg;
	logic [YW-1:0]    y_q;

	assign pos = (16+AW)'(a[15:0]) * (16+AW)'(TABLE_ENTRIES);
	assign sneg = ~ip_s4 + IPW'(1);
	assign ext = {mant_s4, 17'b0} >> sneg;
	assign yneg = (ext + 35'h10000) >> 17;

	always_ff @(posedge clk) begin
		if (en) begin
			ip_s1 <= a[LW-1:16];
			idx_s1 <= pos[16 +: AW];
			r_s1 <= pos[15:0];
			ip_s2 <= ip_s1;
			r_s2 <= r_s1;
			lo_s2 <= EXP_TAB[idx_s1];
			hi_s2 <= EXP_TAB[idx_s1 + AW'(1)];
			ip_s3 <= ip_s2;
			lo_s3 <= lo_s2;
			m_s3 <= 34'(hi_s2 - lo_s2) * 34'(r_s2);
			ip_s4 <= ip_s3;
			mant_s4 <= lo_s3 + 18'((m_s3 + 34'h8000) >> 16);
			if (ip_s4[IPW-1]) y_q <= YW'(yneg);
			else y_q <= YW'({16'b0, mant_s4}) << ip_s4[3:0];
		end
	end

	assign y = y_q;

endmodule

@@ hdl/dtdc_div.sv @@
// dtdc_div: pipelined restoring divider, q = floor(num * 2^16 / den)
// one quotient bit per stage, overflow flag when num >= den; uses dtdc_pkg
module dtdc_div (
	input  logic                    clk,
	input  logic                    en,
	input  logic [dtdc_pkg::DW-1:0] num,
	input  logic [dtdc_pkg::DW-1:0] den,
	output logic                    ovf,
	output logic [dtdc_pkg::QW-1:0] q
);
	import dtdc_pkg::*;

	logic [DW:0]   rem_q [0:QW];
	logic [DW-1:0] den_q [0:QW];
	logic [QW-1:0] q_q   [0:QW];
	logic          ovf_q [0:QW];
	logic [DW:0]   nxt   [1:QW];
	logic          ge    [1:QW];
	logic [DW:0]   sh    [1:QW];

	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			sh[k] = {rem_q[k-1][DW-1:0], 1'b0};
			ge[k] = sh[k] >= {1'b0, den_q[k-1]};
			nxt[k] = ge[k] ? sh[k] - {1'b0, den_q[k-1]} : sh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {1'b0, num};
			den_q[0] <= den;
			ovf_q[0] <= num >= den;
			q_q[0] <= '0;
			for (int k = 1; k <= QW; k++) begin
				rem_q[k] <= nxt[k];
				den_q[k] <= den_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
				q_q[k] <= {q_q[k-1][QW-2:0], ge[k]};
			end
		end
	end

	assign ovf = ovf_q[QW];
	assign q = q_q[QW];

endmodule
